@@ rtl/mtts_pkg.sv @@
`default_nettype none

package mtts_pkg;

    // defaults for the top-level parameters
    localparam int NUM_MOTORS_DEF = 3;
    localparam int CYCLE_BITS_DEF = 16;

    // fixed field widths of the channel payloads
    localparam int STEP_W  = 32;
    localparam int MASK_W  = 3;
    localparam int MOTOR_W = 2;
    localparam int CYC_W   = 16;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HOME,
        PH_RIGHT,
        PH_LEFT
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV
    } seq_state_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [MASK_W-1:0] test_mask;
        logic [CYC_W-1:0]  test_cycles;
        logic [MASK_W-1:0] left_limits;
        logic [MASK_W-1:0] right_limits;
        logic              queue_ready;
    } req_t;

    typedef struct packed {
        logic               step_valid;
        logic [MOTOR_W-1:0] step_motor;
        logic               step_right;
        logic               start_accepted;
        logic               test_active;
        logic [MASK_W-1:0]  calibrated_mask;
        logic [CYC_W-1:0]   cycles_left;
        logic [STEP_W-1:0]  avg_motor0;
        logic [STEP_W-1:0]  avg_motor1;
        logic [STEP_W-1:0]  avg_motor2;
    } rsp_t;

endpackage

`default_nettype wire

@@ rtl/mtts_if.sv @@
`default_nettype none

interface mtts_req_if;
    logic              valid;
    logic              ready;
    mtts_pkg::req_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mtts_rsp_if;
    logic              valid;
    logic              ready;
    mtts_pkg::rsp_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/mtts_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module mtts_div #(
    parameter int CYCLE_BITS = mtts_pkg::CYCLE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [mtts_pkg::STEP_W-1:0] dividend,
    input  wire logic [CYCLE_BITS:0]         divisor,
    output logic                             done,
    output logic [mtts_pkg::STEP_W-1:0]      quotient
);

    localparam int DW    = mtts_pkg::STEP_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]         q_reg,   q_next;
    logic [CYCLE_BITS:0]   r_reg,   r_next;
    logic [CYCLE_BITS:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;

    logic [CYCLE_BITS+1:0] trial;
    logic [CYCLE_BITS+1:0] diff;
    logic                  fits;

    always_comb
    begin
        trial     = {r_reg, q_reg[DW-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        q_next    = q_reg;
        r_next    = r_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            dvs_next = divisor;
            cnt_next = CNT_W'(DW);
        end
        else if (cnt_reg != '0)
        begin
            // remainder stays below the divisor, so the top bit drops safely
            r_next    = fits ? diff[CYCLE_BITS:0] : trial[CYCLE_BITS:0];
            q_next    = {q_reg[DW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

@@ rtl/motor_travel_test_sequencer_top.sv @@
// Motor travel test sequencer.
// req (sink): one beat per command: tick, start test or stop test, with the
//   motor mask, cycle count, limit switch states and downstream queue ready.
// rsp (source): exactly one beat per req beat, carrying the step command
//   issued by that beat plus the status after it (active, calibrated motors,
//   cycles left, per-motor average steps per run).
// Sequence: a beat is taken into a capture register, evaluated in the next
//   cycle, and its rsp beat is valid the cycle after that. When a tick ends
//   a leftward run, the new average goes through the bit-serial divider,
//   which builds the quotient bit by bit, and that rsp beat is valid only
//   after the divider has raised its done flag.
// Concurrency: one beat in flight at a time; the next req beat is not taken
//   until the rsp beat of the last one is issued, also when it needs a divide.
// Reset: clears phase, mask, counters, totals, averages and calibration;
//   rsp is empty and req.ready is high from reset on.
// Stall: the rsp beat waits in its output register; a new req beat is taken
//   in the same cycle the waiting rsp beat is taken, never earlier.
`default_nettype none

module motor_travel_test_sequencer_top #(
    parameter int NUM_MOTORS = mtts_pkg::NUM_MOTORS_DEF,
    parameter int CYCLE_BITS = mtts_pkg::CYCLE_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mtts_req_if.sink    req,
    mtts_rsp_if.source  rsp
);

    localparam int SW = mtts_pkg::STEP_W;
    localparam int MW = $clog2(NUM_MOTORS + 1);                // current motor, incl. "none"
    localparam int IW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1; // array index

    // ---------------------------------------------------------------
    // helpers
    // ---------------------------------------------------------------
    // map a 3-bit port mask onto the motor set; bits past either end drop
    function automatic logic [NUM_MOTORS-1:0] ext_mask(input logic [mtts_pkg::MASK_W-1:0] v);
        logic [NUM_MOTORS-1:0] r;
        r = '0;
        for (int i = 0; i < NUM_MOTORS && i < mtts_pkg::MASK_W; i++)
        begin
            r[i] = v[i];
        end
        return r;
    endfunction

    // first set motor at index >= from, NUM_MOTORS when none
    function automatic logic [MW-1:0] next_sel(input logic [NUM_MOTORS-1:0] mask,
                                               input logic [MW-1:0] from);
        logic [MW-1:0] r;
        logic          found;
        r     = MW'(NUM_MOTORS);
        found = 1'b0;
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            if (!found && m >= int'(from) && mask[m])
            begin
                r     = MW'(m);
                found = 1'b1;
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    mtts_pkg::seq_state_t st_reg, st_next;
    mtts_pkg::phase_t     phase_reg, phase_next;
    mtts_pkg::req_t       cap_reg;

    logic                  active_reg,  active_next;
    logic [NUM_MOTORS-1:0] sel_reg,     sel_next;
    logic [MW-1:0]         cur_reg,     cur_next;
    logic [CYCLE_BITS-1:0] cyc_num_reg, cyc_num_next;
    logic [CYCLE_BITS-1:0] cyc_tgt_reg, cyc_tgt_next;
    logic [CYCLE_BITS-1:0] rem_cyc_reg, rem_cyc_next;
    logic [SW-1:0]         run_reg,     run_next;
    logic [SW-1:0]         total_reg [NUM_MOTORS];
    logic [SW-1:0]         total_next [NUM_MOTORS];
    logic [SW-1:0]         avg_reg [NUM_MOTORS];
    logic [SW-1:0]         avg_next [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] homed_reg,   homed_next;

    // output beat
    logic                       out_valid_reg, out_valid_next;
    logic                       sv_reg,     sv_next;
    logic [mtts_pkg::MOTOR_W-1:0] smot_reg, smot_next;
    logic                       sright_reg, sright_next;
    logic                       acc_reg,    acc_next;
    logic [IW-1:0]              div_idx_reg, div_idx_next;

    // work signals
    logic                  req_rdy;
    logic                  req_take;
    logic [NUM_MOTORS-1:0] lim;
    logic [NUM_MOTORS-1:0] new_sel;
    logic [IW-1:0]         cidx;
    logic [SW-1:0]         tot_sum;
    logic [CYCLE_BITS:0]   div_by;
    logic                  div_start;
    logic                  div_done;
    logic [SW-1:0]         div_q;

    mtts_pkg::rsp_t        rsp_w;
    logic [SW-1:0]         avg_out [3];

    assign req_rdy  = (st_reg == mtts_pkg::ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign req_take = req.valid && req_rdy;

    assign cidx    = cur_reg[IW-1:0];
    assign tot_sum = total_reg[cidx] + run_reg;
    assign div_by  = {cyc_num_reg, 1'b0};
    assign new_sel = ext_mask(cap_reg.test_mask);
    assign lim     = (phase_reg == mtts_pkg::PH_RIGHT) ? ext_mask(cap_reg.right_limits)
                                                       : ext_mask(cap_reg.left_limits);

    // ---------------------------------------------------------------
    // sequencer: evaluate the captured beat, then optionally divide
    // ---------------------------------------------------------------
    always_comb
    begin
        st_next        = st_reg;
        phase_next     = phase_reg;
        active_next    = active_reg;
        sel_next       = sel_reg;
        cur_next       = cur_reg;
        cyc_num_next   = cyc_num_reg;
        cyc_tgt_next   = cyc_tgt_reg;
        rem_cyc_next   = rem_cyc_reg;
        run_next       = run_reg;
        homed_next     = homed_reg;
        total_next     = total_reg;
        avg_next       = avg_reg;
        out_valid_next = out_valid_reg;
        sv_next        = sv_reg;
        smot_next      = smot_reg;
        sright_next    = sright_reg;
        acc_next       = acc_reg;
        div_idx_next   = div_idx_reg;
        div_start      = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (st_reg)
            mtts_pkg::ST_IDLE:
            begin
                if (req_take)
                begin
                    st_next = mtts_pkg::ST_EXEC;
                end
            end

            mtts_pkg::ST_EXEC:
            begin
                sv_next     = 1'b0;
                smot_next   = '0;
                sright_next = 1'b0;
                acc_next    = 1'b0;
                st_next     = mtts_pkg::ST_IDLE;

                case (cap_reg.cmd)
                    mtts_pkg::CMD_START:
                    begin
                        if (!active_reg)
                        begin
                            sel_next     = new_sel;
                            cyc_tgt_next = CYCLE_BITS'(cap_reg.test_cycles);
                            rem_cyc_next = CYCLE_BITS'(cap_reg.test_cycles);
                            cyc_num_next = '0;
                            for (int i = 0; i < NUM_MOTORS; i++)
                            begin
                                total_next[i] = '0;
                                avg_next[i]   = '0;
                            end
                            active_next = 1'b1;
                            acc_next    = 1'b1;
                            phase_next  = mtts_pkg::PH_HOME;
                            cur_next    = next_sel(new_sel, '0);
                            run_next    = '0;
                        end
                    end

                    mtts_pkg::CMD_STOP:
                    begin
                        phase_next   = mtts_pkg::PH_IDLE;
                        active_next  = 1'b0;
                        run_next     = '0;
                        rem_cyc_next = '0;
                    end

                    mtts_pkg::CMD_TICK:
                    begin
                        if (active_reg && phase_reg != mtts_pkg::PH_IDLE)
                        begin
                            if (cur_reg == MW'(NUM_MOTORS))
                            begin
                                // no selected motor left in this phase
                                case (phase_reg)
                                    mtts_pkg::PH_HOME:
                                    begin
                                        if (cyc_tgt_reg == '0)
                                        begin
                                            phase_next  = mtts_pkg::PH_IDLE;
                                            active_next = 1'b0;
                                            run_next    = '0;
                                        end
                                        else
                                        begin
                                            cyc_num_next = CYCLE_BITS'(1);
                                            phase_next   = mtts_pkg::PH_RIGHT;
                                            cur_next     = next_sel(sel_reg, '0);
                                            run_next     = '0;
                                        end
                                    end
                                    mtts_pkg::PH_RIGHT:
                                    begin
                                        phase_next = mtts_pkg::PH_LEFT;
                                        cur_next   = next_sel(sel_reg, '0);
                                        run_next   = '0;
                                    end
                                    default:
                                    begin
                                        rem_cyc_next = cyc_tgt_reg - cyc_num_reg;
                                        if (cyc_num_reg >= cyc_tgt_reg)
                                        begin
                                            phase_next  = mtts_pkg::PH_IDLE;
                                            active_next = 1'b0;
                                            run_next    = '0;
                                        end
                                        else
                                        begin
                                            cyc_num_next = cyc_num_reg + 1'b1;
                                            phase_next   = mtts_pkg::PH_RIGHT;
                                            cur_next     = next_sel(sel_reg, '0);
                                            run_next     = '0;
                                        end
                                    end
                                endcase
                            end
                            else if (lim[cidx])
                            begin
                                // limit reached: run ends, move to next motor
                                if (phase_reg == mtts_pkg::PH_HOME)
                                begin
                                    homed_next[cidx] = 1'b1;
                                end
                                else
                                begin
                                    total_next[cidx] = tot_sum;
                                    if (phase_reg == mtts_pkg::PH_LEFT && div_by != '0)
                                    begin
                                        div_start    = 1'b1;
                                        div_idx_next = cidx;
                                        st_next      = mtts_pkg::ST_DIV;
                                    end
                                end
                                run_next = '0;
                                cur_next = next_sel(sel_reg, cur_reg + 1'b1);
                            end
                            else if (cap_reg.queue_ready)
                            begin
                                sv_next     = 1'b1;
                                smot_next   = mtts_pkg::MOTOR_W'(cur_reg);
                                sright_next = (phase_reg == mtts_pkg::PH_RIGHT);
                                if (phase_reg != mtts_pkg::PH_HOME)
                                begin
                                    run_next = run_reg + 1'b1;
                                end
                            end
                        end
                    end

                    default:
                    begin
                        // unused command code: no change
                    end
                endcase

                if (!div_start)
                begin
                    out_valid_next = 1'b1;
                end
            end

            mtts_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    avg_next[div_idx_reg] = div_q;
                    out_valid_next        = 1'b1;
                    st_next               = mtts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                st_next = mtts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= mtts_pkg::ST_IDLE;
            phase_reg     <= mtts_pkg::PH_IDLE;
            active_reg    <= 1'b0;
            sel_reg       <= '0;
            cur_reg       <= '0;
            cyc_num_reg   <= '0;
            cyc_tgt_reg   <= '0;
            rem_cyc_reg   <= '0;
            run_reg       <= '0;
            homed_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                total_reg[i] <= '0;
                avg_reg[i]   <= '0;
            end
        end
        else
        begin
            st_reg        <= st_next;
            phase_reg     <= phase_next;
            active_reg    <= active_next;
            sel_reg       <= sel_next;
            cur_reg       <= cur_next;
            cyc_num_reg   <= cyc_num_next;
            cyc_tgt_reg   <= cyc_tgt_next;
            rem_cyc_reg   <= rem_cyc_next;
            run_reg       <= run_next;
            homed_reg     <= homed_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
            avg_reg       <= avg_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cap_reg <= req.data;
        end
        sv_reg      <= sv_next;
        smot_reg    <= smot_next;
        sright_reg  <= sright_next;
        acc_reg     <= acc_next;
        div_idx_reg <= div_idx_next;
    end

    // ---------------------------------------------------------------
    // average divider: total / (2 * cycle), one bit per cycle
    // ---------------------------------------------------------------
    mtts_div #(
        .CYCLE_BITS (CYCLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tot_sum),
        .divisor  (div_by),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------------------------------------------------------
    // rsp beat: step fields are registered, status comes straight from
    // state, which only moves after the next req beat is taken
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            avg_out[i] = '0;
        end
        for (int i = 0; i < 3 && i < NUM_MOTORS; i++)
        begin
            avg_out[i] = avg_reg[i];
        end

        rsp_w                 = '0;
        rsp_w.step_valid      = sv_reg;
        rsp_w.step_motor      = smot_reg;
        rsp_w.step_right      = sright_reg;
        rsp_w.start_accepted  = acc_reg;
        rsp_w.test_active     = active_reg;
        for (int i = 0; i < mtts_pkg::MASK_W && i < NUM_MOTORS; i++)
        begin
            rsp_w.calibrated_mask[i] = homed_reg[i];
        end
        rsp_w.cycles_left     = mtts_pkg::CYC_W'(rem_cyc_reg);
        rsp_w.avg_motor0      = avg_out[0];
        rsp_w.avg_motor1      = avg_out[1];
        rsp_w.avg_motor2      = avg_out[2];
    end

    assign req.ready = req_rdy;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = rsp_w;

endmodule

`default_nettype wire

@@ rtl/mtts_chk.sv @@
`default_nettype none

module mtts_chk (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire mtts_pkg::rsp_t rsp_data
);

    // one beat in flight: after a req beat, ready drops
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("req taken while a beat is in flight");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("rsp beat dropped under stall");

    a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.start_accepted) |-> rsp_data.test_active)
        else $error("accepted start without active test");

    a_step_active: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.step_valid) |-> rsp_data.test_active)
        else $error("step issued while no test runs");

    a_no_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.step_valid)
            |-> (rsp_data.step_motor == '0 && !rsp_data.step_right))
        else $error("step fields set without a step");

endmodule

bind motor_travel_test_sequencer_top mtts_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire
